/* rtl/scd_pkg.sv */
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants for the serial CAN frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

    // start bytes that open a frame
    localparam logic [7:0] START_STD_DATA = 8'h55;
    localparam logic [7:0] START_STD_RTR  = 8'h5A;
    localparam logic [7:0] START_EXT_DATA = 8'hA5;
    localparam logic [7:0] START_EXT_RTR  = 8'hAA;

    // bytes of the frame_data field
    localparam int DATA_BYTES = 8;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_ID0   = 3'd1,
        PH_ID1   = 3'd2,
        PH_ID2   = 3'd3,
        PH_ID3   = 3'd4,
        PH_LEN   = 3'd5,
        PH_DATA  = 3'd6,
        PH_CHECK = 3'd7
    } phase_t;

    typedef struct packed {
        logic                      extended;
        logic                      remote;
        logic [31:0]               id;
        logic [3:0]                length;
        logic [DATA_BYTES*8-1:0]   data;
    } frame_t;

endpackage

`default_nettype wire

/* rtl/scd_parser.sv */
// ----------------------------------------------------------------------------
// scd_parser
// Byte-wise frame parser: phase machine, running checksum, id assembly and
// payload store. Flags a good frame while its check byte is presented.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_parser #(
    parameter int MAX_PAYLOAD_BYTES = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          byte_accept,
    input  wire logic [7:0]    rx_byte,
    output scd_pkg::frame_t    frame,
    output logic               frame_hit
);

    localparam int STORE_BYTES = (MAX_PAYLOAD_BYTES < scd_pkg::DATA_BYTES) ?
                                 MAX_PAYLOAD_BYTES : scd_pkg::DATA_BYTES;
    localparam int CNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);

    scd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       sum_reg, sum_next;
    logic [31:0]      id_reg, id_next;
    logic             ext_reg, ext_next;
    logic             rtr_reg, rtr_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       store_reg [STORE_BYTES];
    logic [7:0]       store_next [STORE_BYTES];

    logic [7:0]       sum_add;
    logic [CNT_W-1:0] cnt_inc;
    logic             store_wr;
    logic             is_start;

    assign sum_add = sum_reg + rx_byte;
    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign is_start = (rx_byte == scd_pkg::START_STD_DATA) ||
                      (rx_byte == scd_pkg::START_STD_RTR)  ||
                      (rx_byte == scd_pkg::START_EXT_DATA) ||
                      (rx_byte == scd_pkg::START_EXT_RTR);

    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        id_next    = id_reg;
        ext_next   = ext_reg;
        rtr_next   = rtr_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        store_wr   = 1'b0;
        frame_hit  = 1'b0;
        unique case (phase_reg)
            scd_pkg::PH_HUNT: begin
                sum_next = rx_byte;
                if (is_start) begin
                    ext_next   = (rx_byte == scd_pkg::START_EXT_DATA) ||
                                 (rx_byte == scd_pkg::START_EXT_RTR);
                    rtr_next   = (rx_byte == scd_pkg::START_STD_RTR) ||
                                 (rx_byte == scd_pkg::START_EXT_RTR);
                    phase_next = scd_pkg::PH_ID0;
                end
            end
            scd_pkg::PH_ID0: begin
                sum_next   = sum_add;
                id_next    = {24'd0, rx_byte};
                phase_next = scd_pkg::PH_ID1;
            end
            scd_pkg::PH_ID1: begin
                sum_next   = sum_add;
                id_next    = {id_reg[23:0], rx_byte};
                phase_next = ext_reg ? scd_pkg::PH_ID2 : scd_pkg::PH_LEN;
            end
            scd_pkg::PH_ID2: begin
                sum_next   = sum_add;
                id_next    = {id_reg[23:0], rx_byte};
                phase_next = scd_pkg::PH_ID3;
            end
            scd_pkg::PH_ID3: begin
                sum_next   = sum_add;
                id_next    = {id_reg[23:0], rx_byte};
                phase_next = scd_pkg::PH_LEN;
            end
            scd_pkg::PH_LEN: begin
                sum_next = sum_add;
                if (rx_byte > 8'(MAX_PAYLOAD_BYTES)) begin
                    phase_next = scd_pkg::PH_HUNT;
                end else begin
                    len_next   = rx_byte[CNT_W-1:0];
                    cnt_next   = '0;
                    phase_next = (!rtr_reg && rx_byte != 8'd0) ?
                                 scd_pkg::PH_DATA : scd_pkg::PH_CHECK;
                end
            end
            scd_pkg::PH_DATA: begin
                sum_next = sum_add;
                store_wr = 1'b1;
                cnt_next = cnt_inc;
                if (cnt_inc >= len_reg) begin
                    phase_next = scd_pkg::PH_CHECK;
                end
            end
            scd_pkg::PH_CHECK: begin
                phase_next = scd_pkg::PH_HUNT;
                frame_hit  = (rx_byte == ~sum_reg);
            end
            default: begin
                phase_next = scd_pkg::PH_HUNT;
            end
        endcase
    end

    // counter past the stored bytes matches no entry, so those bytes are dropped
    always_comb begin
        for (int i = 0; i < STORE_BYTES; i++) begin
            store_next[i] = (store_wr && cnt_reg == CNT_W'(i)) ? rx_byte : store_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= scd_pkg::PH_HUNT;
            sum_reg   <= '0;
            id_reg    <= '0;
            ext_reg   <= 1'b0;
            rtr_reg   <= 1'b0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            for (int i = 0; i < STORE_BYTES; i++) begin
                store_reg[i] <= '0;
            end
        end else if (byte_accept) begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            id_reg    <= id_next;
            ext_reg   <= ext_next;
            rtr_reg   <= rtr_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            for (int i = 0; i < STORE_BYTES; i++) begin
                store_reg[i] <= store_next[i];
            end
        end
    end

    assign frame.extended = ext_reg;
    assign frame.remote   = rtr_reg;
    assign frame.id       = id_reg;
    assign frame.length   = 4'(len_reg);

    for (genvar g = 0; g < scd_pkg::DATA_BYTES; g++) begin : g_data
        if (g < STORE_BYTES) begin : g_used
            assign frame.data[g*8 +: 8] = store_reg[g];
        end else begin : g_zero
            assign frame.data[g*8 +: 8] = 8'd0;
        end
    end

    a_data_needs_len : assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == scd_pkg::PH_DATA |-> (!rtr_reg && len_reg != '0))
        else $error("data phase entered for remote or empty frame");

    a_cnt_below_len : assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == scd_pkg::PH_DATA |-> cnt_reg < len_reg)
        else $error("data byte count reached length without leaving data phase");

    a_long_len_drops : assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_accept && phase_reg == scd_pkg::PH_LEN &&
         rx_byte > 8'(MAX_PAYLOAD_BYTES)) |=> phase_reg == scd_pkg::PH_HUNT)
        else $error("oversized length did not drop the frame");

    a_hit_only_check : assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_accept && frame_hit) |=> phase_reg == scd_pkg::PH_HUNT)
        else $error("frame emitted without returning to hunt");

endmodule

`default_nettype wire

/* rtl/scd_out_reg.sv */
// ----------------------------------------------------------------------------
// scd_out_reg
// Result register: holds one decoded frame until the downstream beat.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_out_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire logic             load_valid,
    input  wire scd_pkg::frame_t  load_frame,
    output logic                  load_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output scd_pkg::frame_t       m_frame
);

    logic            valid_reg, valid_next;
    scd_pkg::frame_t frame_reg;

    // a new beat may enter when none is held, or once the held one leaves in this cycle
    assign load_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = load_valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_valid) begin
            frame_reg <= load_frame;
        end
    end

    assign m_valid = valid_reg;
    assign m_frame = frame_reg;

endmodule

`default_nettype wire

/* rtl/serial_can_frame_deframer.sv */
// ----------------------------------------------------------------------------
// serial_can_frame_deframer
// Recovers CAN frames from a serial byte stream, one byte per beat.
// ----------------------------------------------------------------------------
// output: a frame appears on m_ in the cycle after its check byte is accepted
// throughput: one byte per cycle; s_ready drops only while a finished frame
//   is held and m_ready is low (single result register)
// reset: aresetn low clears the parser to hunting, checksum, id, length and
//   payload bytes to zero, and empties the result register
`default_nettype none

module serial_can_frame_deframer #(
    parameter int MAX_PAYLOAD_BYTES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_frame_extended,
    output logic             m_frame_remote,
    output logic [31:0]      m_frame_id,
    output logic [3:0]       m_frame_length,
    output logic [63:0]      m_frame_data
);

    logic            byte_accept;
    logic            frame_hit;
    scd_pkg::frame_t parsed_frame;
    scd_pkg::frame_t out_frame;

    assign byte_accept = s_valid && s_ready;

    scd_parser #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_accept(byte_accept),
        .rx_byte    (s_rx_byte),
        .frame      (parsed_frame),
        .frame_hit  (frame_hit)
    );

    scd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (byte_accept),
        .load_valid(frame_hit),
        .load_frame(parsed_frame),
        .load_ready(s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_frame   (out_frame)
    );

    assign m_frame_extended = out_frame.extended;
    assign m_frame_remote   = out_frame.remote;
    assign m_frame_id       = out_frame.id;
    assign m_frame_length   = out_frame.length;
    assign m_frame_data     = out_frame.data;

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Byte-stream test of serial_can_frame_deframer: directed frames, then random
// clean, corrupted, oversized and truncated frames mixed with line noise.
// Every accepted byte runs through a behavioral deframer. The frames it
// recovers are checked in order against the m_ channel.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_BEATS = 1450;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {
        CLEAN,
        BAD_CHECK,
        BAD_LENGTH,
        CUT_SHORT
    } frame_flaw_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_TOGGLE,
        READY_HELD_OFF
    } ready_mode_t;

    typedef struct {
        logic [7:0] value;
        bit         hold;   // wait for all frames to drain before sending
    } beat_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_frame_extended;
    logic        m_frame_remote;
    logic [31:0] m_frame_id;
    logic [3:0]  m_frame_length;
    logic [63:0] m_frame_data;

    serial_can_frame_deframer u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_extended (m_frame_extended),
        .m_frame_remote   (m_frame_remote),
        .m_frame_id       (m_frame_id),
        .m_frame_length   (m_frame_length),
        .m_frame_data     (m_frame_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    beat_t           pending_beats[$];
    scd_pkg::frame_t expected_frames[$];
    int              beats_planned;
    int              error_count;

    // behavioral deframer state
    scd_pkg::phase_t parse_phase;
    logic [7:0]      byte_sum;
    logic [31:0]     id_shift;
    logic            ext_flag;
    logic            rtr_flag;
    logic [3:0]      want_len;
    logic [3:0]      data_count;
    logic [7:0]      payload [scd_pkg::DATA_BYTES];

    // sender pacing, owned by the driver
    int burst_left;
    int gap_left;
    int frames_predicted;
    int results_taken;

    function automatic bit is_start(logic [7:0] b);
        return b == scd_pkg::START_STD_DATA || b == scd_pkg::START_STD_RTR ||
               b == scd_pkg::START_EXT_DATA || b == scd_pkg::START_EXT_RTR;
    endfunction

    // advance the deframer by one byte; returns 1 when a frame completes with a good check byte
    function automatic bit deframe_byte(input logic [7:0] b, output scd_pkg::frame_t frm);
        frm = '0;
        case (parse_phase)
            scd_pkg::PH_HUNT: begin
                byte_sum = b;
                if (is_start(b)) begin
                    ext_flag    = (b == scd_pkg::START_EXT_DATA ||
                                   b == scd_pkg::START_EXT_RTR);
                    rtr_flag    = (b == scd_pkg::START_STD_RTR ||
                                   b == scd_pkg::START_EXT_RTR);
                    parse_phase = scd_pkg::PH_ID0;
                end
                return 1'b0;
            end
            scd_pkg::PH_ID0: begin
                byte_sum    = byte_sum + b;
                id_shift    = {24'h0, b};
                parse_phase = scd_pkg::PH_ID1;
                return 1'b0;
            end
            scd_pkg::PH_ID1: begin
                byte_sum    = byte_sum + b;
                id_shift    = {id_shift[23:0], b};
                parse_phase = ext_flag ? scd_pkg::PH_ID2 : scd_pkg::PH_LEN;
                return 1'b0;
            end
            scd_pkg::PH_ID2: begin
                byte_sum    = byte_sum + b;
                id_shift    = {id_shift[23:0], b};
                parse_phase = scd_pkg::PH_ID3;
                return 1'b0;
            end
            scd_pkg::PH_ID3: begin
                byte_sum    = byte_sum + b;
                id_shift    = {id_shift[23:0], b};
                parse_phase = scd_pkg::PH_LEN;
                return 1'b0;
            end
            scd_pkg::PH_LEN: begin
                byte_sum = byte_sum + b;
                if (b > scd_pkg::DATA_BYTES) begin
                    parse_phase = scd_pkg::PH_HUNT;
                end else begin
                    want_len    = b[3:0];
                    data_count  = '0;
                    parse_phase = (!rtr_flag && b != 0) ? scd_pkg::PH_DATA
                                                        : scd_pkg::PH_CHECK;
                end
                return 1'b0;
            end
            scd_pkg::PH_DATA: begin
                byte_sum = byte_sum + b;
                if (data_count < scd_pkg::DATA_BYTES)
                    payload[data_count[2:0]] = b;
                data_count = data_count + 1'b1;
                if (data_count >= want_len)
                    parse_phase = scd_pkg::PH_CHECK;
                return 1'b0;
            end
            default: begin
                parse_phase = scd_pkg::PH_HUNT;
                if (b != ~byte_sum)
                    return 1'b0;
                frm.extended = ext_flag;
                frm.remote   = rtr_flag;
                frm.id       = id_shift;
                frm.length   = want_len;
                for (int i = 0; i < scd_pkg::DATA_BYTES; i++)
                    frm.data[8*i +: 8] = payload[i];
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void queue_beat(logic [7:0] value, bit hold);
        beat_t bt;
        bt.value = value;
        bt.hold  = hold;
        pending_beats.insert(pending_beats.size(), bt);
    endfunction

    function automatic void queue_frame(logic [7:0] start, logic [31:0] id, logic [7:0] len,
                                        logic [63:0] data, frame_flaw_t flaw, bit hold);
        logic [7:0] frame_bytes[$];
        logic [7:0] sum;
        int         keep;
        sum = '0;
        frame_bytes.insert(frame_bytes.size(), start);
        if (start == scd_pkg::START_EXT_DATA || start == scd_pkg::START_EXT_RTR) begin
            frame_bytes.insert(frame_bytes.size(), id[31:24]);
            frame_bytes.insert(frame_bytes.size(), id[23:16]);
        end
        frame_bytes.insert(frame_bytes.size(), id[15:8]);
        frame_bytes.insert(frame_bytes.size(), id[7:0]);
        frame_bytes.insert(frame_bytes.size(), len);
        // an oversized length ends the frame right there
        if (flaw != BAD_LENGTH) begin
            if ((start == scd_pkg::START_STD_DATA || start == scd_pkg::START_EXT_DATA) &&
                len != 0) begin
                for (int i = 0; i < len; i++)
                    frame_bytes.insert(frame_bytes.size(), data[8*i +: 8]);
            end
            foreach (frame_bytes[i])
                sum = sum + frame_bytes[i];
            if (flaw == BAD_CHECK)
                frame_bytes.insert(frame_bytes.size(),
                                   ~sum ^ 8'($urandom_range(1, 255)));
            else
                frame_bytes.insert(frame_bytes.size(), ~sum);
        end
        keep = frame_bytes.size();
        if (flaw == CUT_SHORT)
            keep = $urandom_range(1, frame_bytes.size() - 1);
        for (int i = 0; i < keep; i++)
            queue_beat(frame_bytes[i], hold && i == 0);
        beats_planned += keep;
    endfunction

    function automatic void new_burst();
        burst_left = $urandom_range(1, 32);
        case ($urandom_range(0, 5))
            0, 1:    gap_left = 0;
            2:       gap_left = $urandom_range(10, 30);
            default: gap_left = $urandom_range(1, 6);
        endcase
    endfunction

    function automatic logic [7:0] random_start();
        case ($urandom_range(0, 3))
            0:       return scd_pkg::START_STD_DATA;
            1:       return scd_pkg::START_STD_RTR;
            2:       return scd_pkg::START_EXT_DATA;
            default: return scd_pkg::START_EXT_RTR;
        endcase
    endfunction

    task automatic flag_error(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // driver: predicts on every accepted beat, then loads the next one
    always @(posedge aclk) begin : drive_beats
        scd_pkg::frame_t predicted;
        bit              send;
        if (!aresetn) begin
            s_valid          <= 1'b0;
            parse_phase      = scd_pkg::PH_HUNT;
            byte_sum         = '0;
            id_shift         = '0;
            ext_flag         = 1'b0;
            rtr_flag         = 1'b0;
            want_len         = '0;
            data_count       = '0;
            for (int i = 0; i < scd_pkg::DATA_BYTES; i++)
                payload[i] = '0;
            frames_predicted = 0;
            results_taken    = 0;
            new_burst();
        end else begin
            if (m_valid && m_ready)
                results_taken++;
            if (s_valid && s_ready) begin
                if (deframe_byte(s_rx_byte, predicted)) begin
                    expected_frames.insert(expected_frames.size(), predicted);
                    frames_predicted++;
                end
            end
            if (!s_valid || s_ready) begin
                send = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_beats.size() != 0 &&
                             !(pending_beats[0].hold && frames_predicted != results_taken)) begin
                    send = 1'b1;
                    s_rx_byte <= pending_beats[0].value;
                    void'(pending_beats.pop_front());
                    if (burst_left <= 1)
                        new_burst();
                    else
                        burst_left--;
                end
                s_valid <= send;
            end
        end
    end

    // receiver back-pressure pattern
    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_left  = 0;

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 4));
            mode_left  = $urandom_range(8, 64);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_COIN:   m_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: m_ready <= ($urandom_range(0, 4) == 0);
            READY_TOGGLE: m_ready <= ~m_ready;
            default:      m_ready <= 1'b0;
        endcase
    end

    // monitor and watchdog
    int idle_cycles = 0;

    always @(posedge aclk) begin : check_frames
        scd_pkg::frame_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    flag_error($sformatf("unexpected frame id %h", m_frame_id));
                end else begin
                    want = expected_frames.pop_front();
                    if (m_frame_extended !== want.extended)
                        flag_error($sformatf("frame_extended got %b want %b",
                                             m_frame_extended, want.extended));
                    if (m_frame_remote !== want.remote)
                        flag_error($sformatf("frame_remote got %b want %b",
                                             m_frame_remote, want.remote));
                    if (m_frame_id !== want.id)
                        flag_error($sformatf("frame_id got %h want %h", m_frame_id, want.id));
                    if (m_frame_length !== want.length)
                        flag_error($sformatf("frame_length got %0d want %0d",
                                             m_frame_length, want.length));
                    if (m_frame_data !== want.data)
                        flag_error($sformatf("frame_data got %h want %h",
                                             m_frame_data, want.data));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        int          pick;
        logic [7:0]  len;
        frame_flaw_t flaw;

        error_count   = 0;
        beats_planned = 0;

        // noise while hunting, then a remote frame showing the cleared payload
        queue_beat(8'h00, 1'b0);
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'h56, 1'b0);
        queue_frame(scd_pkg::START_STD_RTR, 32'h0000_FFFF, 8'd0, '0, CLEAN, 1'b0);
        queue_frame(scd_pkg::START_EXT_DATA, 32'hFFFF_FFFF, 8'd8, 64'h0123_4567_89AB_CDEF,
                    CLEAN, 1'b0);
        // short frame leaves bytes 2..7 stale
        queue_frame(scd_pkg::START_STD_DATA, 32'h0000_0000, 8'd2, 64'h0000_0000_0000_A55A,
                    CLEAN, 1'b0);
        queue_frame(scd_pkg::START_EXT_RTR, 32'h0000_0000, 8'd8, '0, CLEAN, 1'b1);
        queue_frame(scd_pkg::START_STD_DATA, 32'h0000_1234, 8'd9, '0, BAD_LENGTH, 1'b0);
        queue_frame(scd_pkg::START_STD_DATA, 32'h0000_8001, 8'd0, '0, CLEAN, 1'b0);
        queue_frame(scd_pkg::START_EXT_DATA, 32'h1ABC_DEF0, 8'd3, 64'hFF_FF_FF, BAD_CHECK,
                    1'b0);
        queue_frame(scd_pkg::START_STD_RTR, 32'h0000_7FF0, 8'd5, '0, CLEAN, 1'b0);
        queue_frame(scd_pkg::START_EXT_DATA, 32'h0000_0001, 8'd255, '0, BAD_LENGTH, 1'b0);

        beats_planned = 0;
        while (beats_planned < RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick >= 95) begin
                repeat ($urandom_range(1, 4))
                    queue_beat(8'($urandom), 1'b0);
            end else begin
                if (pick < 70)      flaw = CLEAN;
                else if (pick < 80) flaw = BAD_CHECK;
                else if (pick < 87) flaw = BAD_LENGTH;
                else                flaw = CUT_SHORT;
                if (flaw == BAD_LENGTH) begin
                    len = 8'($urandom_range(9, 255));
                end else begin
                    case ($urandom_range(0, 9))
                        9:       len = 8'd8;
                        8:       len = 8'd0;
                        default: len = 8'($urandom_range(0, 8));
                    endcase
                end
                queue_frame(random_start(), $urandom, len, {$urandom, $urandom}, flaw,
                            $urandom_range(0, 29) == 0);
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_beats.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_frames.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/scd_pkg.sv
rtl/scd_parser.sv
rtl/scd_out_reg.sv
rtl/serial_can_frame_deframer.sv
sim/testbench.sv
